/* design/csph_pkg.sv */
`timescale 1ns / 1ps
// shared constants, sideband type and arctangent table for the cartesian to spherical core
// no dependencies; imported by csph_cordic and cartesian_to_spherical_core
package csph_pkg;

	// default configuration and limits
	localparam int DEF_DATA_WIDTH    = 16;
	localparam int DEF_CORDIC_STAGES = 16;
	localparam int MAX_STAGES        = 24;
	localparam int OUT_W             = 16;

	// fixed-point layout of the datapath
	localparam int GUARD_BITS  = 8;
	localparam int HEADROOM    = 3;
	localparam int ANGLE_W     = 32;
	localparam int SIDE_DATA_W = 32;
	localparam int ANGLE_SHIFT = 13;

	// angle units: pi / 2^28
	localparam logic signed [ANGLE_W-1:0] HALF_TURN   = 32'sd268435456;
	localparam logic signed [ANGLE_W-1:0] ROUND_ANGLE = 32'sd4096;

	// asymptotic inverse cordic gain in q16
	localparam logic [17:0] INV_GAIN = 18'd39797;

	// flags and values that ride along with a transaction
	typedef struct packed {
		logic                           all_zero;
		logic                           xy_zero;
		logic signed [SIDE_DATA_W-1:0] z;
		logic signed [ANGLE_W-1:0]     azimuth;
	} csph_side_t;

	// round(atan(2^-i) * 2^28 / pi)
	function automatic logic signed [ANGLE_W-1:0] atan_unit(input logic [4:0] idx);
		logic signed [ANGLE_W-1:0] v;
		case (idx)
			5'd0: v = 32'sd67108864;
			5'd1: v = 32'sd39616676;
			5'd2: v = 32'sd20932363;
			5'd3: v = 32'sd10625595;
			5'd4: v = 32'sd5333416;
			5'd5: v = 32'sd2669308;
			5'd6: v = 32'sd1334980;
			5'd7: v = 32'sd667531;
			5'd8: v = 32'sd333770;
			5'd9: v = 32'sd166886;
			5'd10: v = 32'sd83443;
			5'd11: v = 32'sd41722;
			5'd12: v = 32'sd20861;
			5'd13: v = 32'sd10430;
			5'd14: v = 32'sd5215;
			5'd15: v = 32'sd2608;
			5'd16: v = 32'sd1304;
			5'd17: v = 32'sd652;
			5'd18: v = 32'sd326;
			5'd19: v = 32'sd163;
			5'd20: v = 32'sd81;
			5'd21: v = 32'sd41;
			5'd22: v = 32'sd20;
			5'd23: v = 32'sd10;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* design/cartesian_to_spherical_core.sv */
`timescale 1ns / 1ps
// cartesian to spherical conversion core: input register, two chained cordics, output formatting
// depends on csph_pkg and csph_cordic
//
// Converts one signed (x, y, z) point per transaction into radius, polar angle and azimuth,
// with angles in binary units where 32768 is pi. The core is fully pipelined: busy is always
// low, a new point may be started in every clock cycle, and each result appears on the result
// ports with done high for exactly one cycle. The path runs through the two unrolled vectoring
// cordics, each with one pre-rotation stage, CORDIC_STAGES micro-rotation stages and two
// gain-compensation stages, plus one input and one output register. The receiver cannot stall
// the core and must take every result in the cycle it is shown.
module cartesian_to_spherical_core #(
	parameter int DATA_WIDTH    = csph_pkg::DEF_DATA_WIDTH,
	parameter int CORDIC_STAGES = csph_pkg::DEF_CORDIC_STAGES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [DATA_WIDTH-1:0]        x_coord,
	input  logic signed [DATA_WIDTH-1:0]        y_coord,
	input  logic signed [DATA_WIDTH-1:0]        z_coord,
	output logic                                done,
	output logic [csph_pkg::OUT_W-1:0]          radius,
	output logic [csph_pkg::OUT_W-1:0]          polar_angle,
	output logic signed [csph_pkg::OUT_W-1:0]   azimuth_angle
);
	import csph_pkg::*;

	localparam int NS  = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
	localparam int W   = DATA_WIDTH + GUARD_BITS + HEADROOM;
	localparam int RW  = W + 1 - GUARD_BITS;
	localparam int LAT = 2 * NS + 8;
	localparam logic [RW-1:0] RMAX = RW'({DATA_WIDTH{1'b1}});
	localparam logic [W:0]    RAD_HALF = (W+1)'(1 << (GUARD_BITS - 1));

	// input stage
	logic                        vld_s1;
	logic signed [W-1:0]         xa_s1;
	logic signed [W-1:0]         ya_s1;
	csph_side_t                  side_s1;

	// cordic links
	logic                        c1_valid;
	logic signed [W-1:0]         c1_len;
	logic signed [ANGLE_W-1:0]   c1_ang;
	csph_side_t                  c1_side;
	csph_side_t                  c2_side_in;
	logic signed [W-1:0]         za;
	logic                        c2_valid;
	logic signed [W-1:0]         c2_len;
	logic signed [ANGLE_W-1:0]   c2_ang;
	csph_side_t                  c2_side;

	// output formatting
	logic [W:0]                  rad_rnd;
	logic [RW-1:0]               rad_sh;
	logic [RW-1:0]               rad_sat;
	logic signed [ANGLE_W-1:0]   pol_clamp;
	logic signed [ANGLE_W-1:0]   pol_rnd;
	logic signed [ANGLE_W-1:0]   az_rnd;
	logic                        done_s2;
	logic [OUT_W-1:0]            radius_s2;
	logic [OUT_W-1:0]            polar_s2;
	logic [OUT_W-1:0]            azim_s2;

	// fully pipelined, never holds off a transaction
	assign busy = 1'b0;

	// capture the point with guard bits and special-case flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		xa_s1 <= $signed({{(W-GUARD_BITS-DATA_WIDTH){x_coord[DATA_WIDTH-1]}}, x_coord,
			{GUARD_BITS{1'b0}}});
		ya_s1 <= $signed({{(W-GUARD_BITS-DATA_WIDTH){y_coord[DATA_WIDTH-1]}}, y_coord,
			{GUARD_BITS{1'b0}}});
		side_s1.all_zero <= (x_coord == '0) && (y_coord == '0) && (z_coord == '0);
		side_s1.xy_zero  <= (x_coord == '0) && (y_coord == '0);
		side_s1.z        <= SIDE_DATA_W'(z_coord);
		side_s1.azimuth  <= '0;
	end

	// planar length and azimuth from (x, y)
	csph_cordic #(
		.DATA_WIDTH (DATA_WIDTH),
		.STAGES     (NS)
	) u_cordic_xy (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_a      (xa_s1),
		.in_b      (ya_s1),
		.in_side   (side_s1),
		.out_valid (c1_valid),
		.out_len   (c1_len),
		.out_ang   (c1_ang),
		.out_side  (c1_side)
	);

	// second cordic takes (z, planar length); azimuth rides in the sideband
	always_comb begin
		c2_side_in         = c1_side;
		c2_side_in.azimuth = c1_ang;
	end

	assign za = $signed({{(W-GUARD_BITS-DATA_WIDTH){c1_side.z[DATA_WIDTH-1]}},
		c1_side.z[DATA_WIDTH-1:0], {GUARD_BITS{1'b0}}});

	csph_cordic #(
		.DATA_WIDTH (DATA_WIDTH),
		.STAGES     (NS)
	) u_cordic_rz (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c1_valid),
		.in_a      (za),
		.in_b      (c1_len),
		.in_side   (c2_side_in),
		.out_valid (c2_valid),
		.out_len   (c2_len),
		.out_ang   (c2_ang),
		.out_side  (c2_side)
	);

	// round radius off the guard bits and saturate; clamp and round the angles
	always_comb begin
		rad_rnd = {1'b0, c2_len} + RAD_HALF;
		rad_sh  = rad_rnd[W:GUARD_BITS];
		rad_sat = (rad_sh > RMAX) ? RMAX : rad_sh;
		if (c2_ang < 0) begin
			pol_clamp = '0;
		end else if (c2_ang > HALF_TURN) begin
			pol_clamp = HALF_TURN;
		end else begin
			pol_clamp = c2_ang;
		end
		pol_rnd = pol_clamp + ROUND_ANGLE;
		az_rnd  = c2_side.azimuth + ROUND_ANGLE;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= c2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (c2_side.all_zero) begin
			radius_s2 <= '0;
			polar_s2  <= '0;
			azim_s2   <= '0;
		end else begin
			radius_s2 <= OUT_W'(rad_sat);
			polar_s2  <= pol_rnd[ANGLE_SHIFT+OUT_W-1:ANGLE_SHIFT];
			azim_s2   <= c2_side.xy_zero ? '0 : az_rnd[ANGLE_SHIFT+OUT_W-1:ANGLE_SHIFT];
		end
	end

	assign done          = done_s2;
	assign radius        = radius_s2;
	assign polar_angle   = polar_s2;
	assign azimuth_angle = $signed(azim_s2);

`ifndef SYNTHESIS
	// every started transaction comes out exactly once, after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy && arst_n, LAT))
		else $error("result strobe does not match a start LAT cycles earlier");

	// the origin maps to all-zero outputs
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy && arst_n && x_coord == '0 && y_coord == '0 && z_coord == '0, LAT)
		|-> (done && radius == '0 && polar_angle == '0 && azimuth_angle == '0))
		else $error("origin point gave a nonzero result");

	// points on the z axis have zero azimuth
	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy && arst_n && x_coord == '0 && y_coord == '0, LAT)
		|-> (azimuth_angle == '0))
		else $error("point on z axis gave nonzero azimuth");

	// polar angle never leaves [0, pi]
	a_polar: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (polar_angle <= 16'd32768))
		else $error("polar angle above pi");
`endif

endmodule

/* design/csph_cordic.sv */
`timescale 1ns / 1ps
// pipelined vectoring cordic: pre-rotation, unrolled micro-rotations, gain compensation
// depends on csph_pkg
module csph_cordic #(
	parameter int DATA_WIDTH = csph_pkg::DEF_DATA_WIDTH,
	parameter int STAGES     = csph_pkg::DEF_CORDIC_STAGES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [DATA_WIDTH+csph_pkg::GUARD_BITS+csph_pkg::HEADROOM-1:0] in_a,
	input  logic signed [DATA_WIDTH+csph_pkg::GUARD_BITS+csph_pkg::HEADROOM-1:0] in_b,
	input  csph_pkg::csph_side_t    in_side,
	output logic                    out_valid,
	output logic signed [DATA_WIDTH+csph_pkg::GUARD_BITS+csph_pkg::HEADROOM-1:0] out_len,
	output logic signed [csph_pkg::ANGLE_W-1:0] out_ang,
	output csph_pkg::csph_side_t    out_side
);
	import csph_pkg::*;

	localparam int W     = DATA_WIDTH + GUARD_BITS + HEADROOM;
	localparam int PW    = W + 18;
	localparam int DEPTH = STAGES + 3;
	localparam logic signed [PW-1:0] GAIN_S = PW'(INV_GAIN);
	localparam logic signed [PW-1:0] RND_C  = PW'(32768);

	logic [DEPTH-1:0]           vld_s;
	csph_side_t                 side_s [0:DEPTH-1];
	logic signed [W-1:0]        a_s    [0:STAGES];
	logic signed [W-1:0]        b_s    [0:STAGES];
	logic signed [ANGLE_W-1:0]  acc_s  [0:STAGES];
	logic signed [PW-1:0]       prod_s;
	logic signed [PW-1:0]       rnd_s;
	logic signed [ANGLE_W-1:0]  acc_m_s;
	logic signed [ANGLE_W-1:0]  acc_r_s;

	// valid bits follow the data through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[DEPTH-2:0], in_valid};
		end
	end

	// sideband delay line
	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		for (int i = 1; i < DEPTH; i++) begin
			side_s[i] <= side_s[i-1];
		end
	end

	// pre-rotation by pi into the right half plane
	always_ff @(posedge clk) begin
		if (in_a[W-1]) begin
			a_s[0]   <= -in_a;
			b_s[0]   <= -in_b;
			acc_s[0] <= HALF_TURN;
		end else begin
			a_s[0]   <= in_a;
			b_s[0]   <= in_b;
			acc_s[0] <= '0;
		end
	end

	// one micro-rotation per stage, driving the residual toward zero
	for (genvar k = 0; k < STAGES; k++) begin : g_rot
		localparam logic signed [ANGLE_W-1:0] ATAN_K = atan_unit(5'(k));
		always_ff @(posedge clk) begin
			if (!b_s[k][W-1]) begin
				a_s[k+1]   <= a_s[k] + (b_s[k] >>> k);
				b_s[k+1]   <= b_s[k] - (a_s[k] >>> k);
				acc_s[k+1] <= acc_s[k] + ATAN_K;
			end else begin
				a_s[k+1]   <= a_s[k] - (b_s[k] >>> k);
				b_s[k+1]   <= b_s[k] + (a_s[k] >>> k);
				acc_s[k+1] <= acc_s[k] - ATAN_K;
			end
		end
	end

	// gain compensation: multiply, then round half up
	always_ff @(posedge clk) begin
		prod_s  <= PW'(a_s[STAGES]) * GAIN_S;
		acc_m_s <= acc_s[STAGES];
		rnd_s   <= prod_s + RND_C;
		acc_r_s <= acc_m_s;
	end

	assign out_valid = vld_s[DEPTH-1];
	assign out_len   = $signed(rnd_s[W+15:16]);
	assign out_ang   = acc_r_s;
	assign out_side  = side_s[DEPTH-1];

endmodule

/* test/cartesian_to_spherical_core_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for cartesian_to_spherical_core: directed and random points
// depends on csph_pkg and the core; holds its own bit-exact cordic predictor and scoreboard

module cartesian_to_spherical_core_tb;

	localparam int    COORD_W        = csph_pkg::DEF_DATA_WIDTH;
	localparam int    STAGES         = csph_pkg::DEF_CORDIC_STAGES;
	localparam int    LATENCY        = 2 * STAGES + 8;
	localparam int    WATCHDOG_LIMIT = 1000;
	localparam int    RANDOM_PER_PHASE = 210;
	localparam longint HALF_TURN_UNITS = 64'sd268435456;
	localparam longint GAIN_COMP       = 64'sd39797;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct {
		logic [csph_pkg::OUT_W-1:0]        radius;
		logic [csph_pkg::OUT_W-1:0]        polar;
		logic signed [csph_pkg::OUT_W-1:0] azimuth;
	} spherical_t;

	logic   clk    = 1'b0;
	logic   arst_n = 1'b0;
	logic   start  = 1'b0;
	coord_t x_coord = '0;
	coord_t y_coord = '0;
	coord_t z_coord = '0;
	logic   busy;
	logic   done;
	logic [csph_pkg::OUT_W-1:0]        radius;
	logic [csph_pkg::OUT_W-1:0]        polar_angle;
	logic signed [csph_pkg::OUT_W-1:0] azimuth_angle;

	point_t     points_pending[$];
	spherical_t spherical_due[$];
	int         sender_idle_pct = 8;
	logic       item_taken = 1'b0;
	int         stall_cycles = 0;
	int         mismatches = 0;
	int         points_converted = 0;
	int         results_checked = 0;
	int         axis_points = 0;

	cartesian_to_spherical_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.z_coord       (z_coord),
		.done          (done),
		.radius        (radius),
		.polar_angle   (polar_angle),
		.azimuth_angle (azimuth_angle)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// arctangent steps in units of pi / 2^28
	function automatic longint atan_step(input int i);
		case (i)
			0: return 64'sd67108864;
			1: return 64'sd39616676;
			2: return 64'sd20932363;
			3: return 64'sd10625595;
			4: return 64'sd5333416;
			5: return 64'sd2669308;
			6: return 64'sd1334980;
			7: return 64'sd667531;
			8: return 64'sd333770;
			9: return 64'sd166886;
			10: return 64'sd83443;
			11: return 64'sd41722;
			12: return 64'sd20861;
			13: return 64'sd10430;
			14: return 64'sd5215;
			15: return 64'sd2608;
			16: return 64'sd1304;
			17: return 64'sd652;
			18: return 64'sd326;
			19: return 64'sd163;
			20: return 64'sd81;
			21: return 64'sd41;
			22: return 64'sd20;
			default: return 64'sd10;
		endcase
	endfunction

	// vectoring cordic: gain-compensated length and atan2(b, a)
	function automatic void cordic_vectoring(input longint a_in, input longint b_in,
			output longint len, output longint ang);
		longint a;
		longint b;
		longint acc;
		longint da;
		longint db;
		a = a_in;
		b = b_in;
		acc = 0;
		// pre-rotation by pi for the left half plane
		if (a < 0) begin
			a = -a;
			b = -b;
			acc = HALF_TURN_UNITS;
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			da = b >>> i;
			db = a >>> i;
			// a zero residual counts as non-negative
			if (b >= 0) begin
				a = a + da;
				b = b - db;
				acc = acc + atan_step(i);
			end else begin
				a = a - da;
				b = b + db;
				acc = acc - atan_step(i);
			end
		end
		len = (a * GAIN_COMP + 64'sd32768) >>> 16;
		ang = acc;
	endfunction

	// expected spherical triple for one point
	function automatic spherical_t to_spherical(input point_t p);
		spherical_t s;
		longint rxy;
		longint az;
		longint rad;
		longint pol;
		longint r_rnd;
		longint az_rnd;
		if (p.x == 0 && p.y == 0 && p.z == 0) begin
			s.radius = '0;
			s.polar = '0;
			s.azimuth = '0;
			return s;
		end
		cordic_vectoring(longint'(p.x) * 256, longint'(p.y) * 256, rxy, az);
		cordic_vectoring(longint'(p.z) * 256, rxy, rad, pol);
		// radius rounded from the guard bits, saturating
		r_rnd = (rad + 128) >>> 8;
		s.radius = (r_rnd > 65535) ? 16'hffff : r_rnd[15:0];
		// polar angle clamped to [0, pi]
		if (pol < 0)
			pol = 0;
		if (pol > HALF_TURN_UNITS)
			pol = HALF_TURN_UNITS;
		pol = (pol + 4096) >>> 13;
		s.polar = pol[15:0];
		// azimuth wraps modulo a full turn, zero on the z axis
		az_rnd = (az + 4096) >>> 13;
		s.azimuth = (p.x == 0 && p.y == 0) ? 16'sd0 : az_rnd[15:0];
		return s;
	endfunction

	task automatic add_point(input int x, input int y, input int z);
		point_t p;
		p.x = coord_t'(x);
		p.y = coord_t'(y);
		p.z = coord_t'(z);
		points_pending.push_back(p);
	endtask

	// one coordinate: full range, small, or an extreme value
	function automatic coord_t pick_coord();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1: return coord_t'($urandom_range(0, 30)) - coord_t'(15);
			2: begin
				case ($urandom_range(0, 4))
					0: return coord_t'(-32768);
					1: return coord_t'(32767);
					2: return coord_t'(-1);
					3: return coord_t'(1);
					default: return coord_t'(0);
				endcase
			end
			3: return coord_t'($urandom_range(0, 511)) - coord_t'(256);
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic add_random_points(input int count);
		point_t p;
		for (int n = 0; n < count; n++) begin
			p.x = pick_coord();
			p.y = pick_coord();
			p.z = pick_coord();
			// bias toward the z axis, the xy plane and the xz plane
			case ($urandom_range(0, 9))
				0: begin
					p.x = '0;
					p.y = '0;
				end
				1: p.z = '0;
				2: p.y = '0;
				default: ;
			endcase
			points_pending.push_back(p);
		end
	endtask

	task automatic wait_drained();
		while (points_pending.size() != 0 || spherical_due.size() != 0 || start)
			@(posedge clk);
	endtask

	// driver: presents the next point at the falling edge
	always @(negedge clk) begin
		point_t p;
		logic   next_start;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || item_taken) begin
			next_start = 1'b0;
			if (points_pending.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				p = points_pending.pop_front();
				next_start = 1'b1;
			end else begin
				p.x = coord_t'($urandom);
				p.y = coord_t'($urandom);
				p.z = coord_t'($urandom);
			end
			start   <= next_start;
			x_coord <= p.x;
			y_coord <= p.y;
			z_coord <= p.z;
		end
	end

	// monitor: scoreboard check, expectation capture and watchdog
	always @(posedge clk) begin
		spherical_t want;
		point_t     p;
		logic       taken;
		taken = arst_n && start && !busy;
		item_taken <= taken;
		if (arst_n && done) begin
			results_checked++;
			if (spherical_due.size() == 0) begin
				$error("result with no pending transaction: radius %0d polar %0d azimuth %0d",
					radius, polar_angle, azimuth_angle);
				mismatches++;
			end else begin
				want = spherical_due.pop_front();
				if (radius !== want.radius) begin
					$error("radius: expected %0d, got %0d", want.radius, radius);
					mismatches++;
				end
				if (polar_angle !== want.polar) begin
					$error("polar_angle: expected %0d, got %0d", want.polar, polar_angle);
					mismatches++;
				end
				if (azimuth_angle !== want.azimuth) begin
					$error("azimuth_angle: expected %0d, got %0d", want.azimuth, azimuth_angle);
					mismatches++;
				end
			end
		end
		if (taken) begin
			p.x = x_coord;
			p.y = y_coord;
			p.z = z_coord;
			spherical_due.push_back(to_spherical(p));
			points_converted++;
			if (p.x == 0 && p.y == 0)
				axis_points++;
		end
		if (taken || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// origin, axes and their extremes
		add_point(0, 0, 0);
		add_point(32767, 0, 0);
		add_point(-32768, 0, 0);
		add_point(-1, 0, 0);
		add_point(1, 0, 0);
		add_point(0, 32767, 0);
		add_point(0, -32768, 0);
		add_point(0, 0, 32767);
		add_point(0, 0, -32768);
		add_point(0, 0, 1);
		add_point(0, 0, -1);
		// largest radius and the corners
		add_point(-32768, -32768, -32768);
		add_point(32767, 32767, 32767);
		add_point(32767, -32768, 32767);
		add_point(-32768, 32767, -32768);
		// azimuth near the wrap at +-pi
		add_point(-32768, 1, 0);
		add_point(-32768, -1, 0);
		add_point(-1, -1, 0);
		add_point(-1, 1, -1);
		// small vectors where rounding dominates
		add_point(1, 1, 1);
		add_point(-1, -1, -1);
		add_point(3, 4, 0);
		add_point(0, 1, -1);
		add_point(5, -12, 13);

		// phase with a mostly busy sender
		sender_idle_pct = 8;
		add_random_points(RANDOM_PER_PHASE);
		wait_drained();

		// phase with a mostly idle sender
		sender_idle_pct = 52;
		add_random_points(RANDOM_PER_PHASE);
		wait_drained();

		// back-to-back phase
		sender_idle_pct = 0;
		add_random_points(RANDOM_PER_PHASE);
		wait_drained();

		// let any stray result show up
		repeat (LATENCY + 8) @(posedge clk);

		$display("converted %0d points (%0d on the z axis) at three sender duty cycles",
			points_converted, axis_points);
		$display("checked %0d results, %0d field mismatches", results_checked, mismatches);
		if (mismatches == 0 && spherical_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
